// File: rtl/ictf_pkg.sv
`timescale 1ns / 1ps
package ictf_pkg;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_BLEND_ALPHA = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_GAIN   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACC_BIAS_X  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ACC_BIAS_Y  = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ACC_BIAS_Z  = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GYR_BIAS_X  = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GYR_BIAS_Y  = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_GYR_BIAS_Z  = 8'd7;

  localparam logic [16:0] ALPHA_ONE      = 17'd65536;
  localparam logic [16:0] ALPHA_RESET    = 17'd64225;
  localparam logic [23:0] GAIN_RESET     = 24'd131142;
  localparam logic signed [25:0] DEG90   = 26'sd5898240;
  localparam logic [4:0] ROOT_LAST       = 5'd31;
  localparam logic [3:0] CORDIC_LAST     = 4'd15;

  typedef struct packed {
    logic signed [16:0] ax;
    logic signed [16:0] ay;
    logic signed [17:0] az;
    logic signed [16:0] rx;
    logic signed [16:0] ry;
    logic signed [16:0] rz;
  } ictf_item_t;

  typedef struct packed {
    logic [16:0]        blend_alpha;
    logic [23:0]        gyro_step_gain;
    logic signed [15:0] abx;
    logic signed [15:0] aby;
    logic signed [16:0] abz;
    logic signed [15:0] gbx;
    logic signed [15:0] gby;
    logic signed [15:0] gbz;
  } ictf_cfg_t;

  // atan(2^-i) in 2^-16 degree
  function automatic logic [21:0] atan_lut(input logic [3:0] i);
    logic [21:0] v;
    case (i)
      4'd0:    v = 22'd2949120;
      4'd1:    v = 22'd1740967;
      4'd2:    v = 22'd919879;
      4'd3:    v = 22'd466945;
      4'd4:    v = 22'd234379;
      4'd5:    v = 22'd117304;
      4'd6:    v = 22'd58666;
      4'd7:    v = 22'd29335;
      4'd8:    v = 22'd14668;
      4'd9:    v = 22'd7334;
      4'd10:   v = 22'd3667;
      4'd11:   v = 22'd1833;
      4'd12:   v = 22'd917;
      4'd13:   v = 22'd458;
      4'd14:   v = 22'd229;
      default: v = 22'd115;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/ictf_front.sv
`timescale 1ns / 1ps
module ictf_front import ictf_pkg::*; (
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,
  input  ictf_cfg_t   cfg,
  input  logic        q_full,
  output logic        q_push,
  output ictf_item_t  q_item
);
  logic signed [15:0] acx, acy, acz, gx, gy, gz;

  assign acx = in_tdata[15:0];
  assign acy = in_tdata[31:16];
  assign acz = in_tdata[47:32];
  assign gx  = in_tdata[63:48];
  assign gy  = in_tdata[79:64];
  assign gz  = in_tdata[95:80];

  assign in_tready = rst_n & ~q_full;
  assign q_push    = in_tvalid & in_tready;

  // bias removal, widened so nothing wraps
  assign q_item.ax = {acx[15], acx} - {cfg.abx[15], cfg.abx};
  assign q_item.ay = {acy[15], acy} - {cfg.aby[15], cfg.aby};
  assign q_item.az = {{2{acz[15]}}, acz} - {cfg.abz[16], cfg.abz};
  assign q_item.rx = {gx[15], gx} - {cfg.gbx[15], cfg.gbx};
  assign q_item.ry = {gy[15], gy} - {cfg.gby[15], cfg.gby};
  assign q_item.rz = {gz[15], gz} - {cfg.gbz[15], cfg.gbz};
endmodule

// File: rtl/ictf_queue.sv
`timescale 1ns / 1ps
module ictf_queue import ictf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  ictf_item_t push_item,
  input  logic       pop,
  output ictf_item_t head_item,
  output logic       full,
  output logic       empty
);
  ictf_item_t  slot_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  cnt_r;

  assign full      = (cnt_r == 2'd2);
  assign empty     = (cnt_r == 2'd0);
  assign head_item = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// File: rtl/ictf_back.sv
`timescale 1ns / 1ps
module ictf_back import ictf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  ictf_cfg_t   cfg,
  input  logic        q_empty,
  input  ictf_item_t  q_head,
  output logic        q_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata
);
  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_SQ1  = 11'b00000000010,
    S_SQ2  = 11'b00000000100,
    S_ROOT = 11'b00000001000,
    S_CORD = 11'b00000010000,
    S_BM1  = 11'b00000100000,
    S_BG   = 11'b00001000000,
    S_BM2  = 11'b00010000000,
    S_BM3  = 11'b00100000000,
    S_BS   = 11'b01000000000,
    S_OUT  = 11'b10000000000
  } state_t;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [25:0] z;
  } cvec_t;

  function automatic cvec_t prerot(input logic signed [33:0] x, input logic signed [33:0] y);
    cvec_t v;
    if (x < 0) begin
      if (y >= 0) begin
        v.x = y; v.y = -x; v.z = DEG90;
      end else begin
        v.x = -y; v.y = x; v.z = -DEG90;
      end
    end else begin
      v.x = x; v.y = y; v.z = 26'sd0;
    end
    return v;
  endfunction

  function automatic cvec_t cstep(input cvec_t v, input logic [3:0] i);
    cvec_t n;
    logic signed [33:0] xs, ys;
    logic signed [25:0] t;
    xs = v.x >>> i;
    ys = v.y >>> i;
    t  = $signed({4'b0, atan_lut(i)});
    if (v.y > 0) begin
      n.x = v.x + ys; n.y = v.y - xs; n.z = v.z + t;
    end else begin
      n.x = v.x - ys; n.y = v.y + xs; n.z = v.z - t;
    end
    return n;
  endfunction

  state_t              state_r, state_nxt;
  ictf_item_t          item_r;
  logic [35:0]         sq_r;
  logic [63:0]         rem_r, res_r, bit_r;
  logic [4:0]          cnt_r;
  cvec_t               c0_r, c1_r;
  logic                z0_r, z1_r;
  logic                lane_r;
  logic signed [41:0]  prod_r;
  logic signed [42:0]  d_r;
  logic [38:0]         lo_r;
  logic signed [38:0]  hi_r;
  logic signed [15:0]  roll_r, pitch_r;
  logic                out_valid_r;
  logic [87:0]         out_data_r;

  // per-lane selection for the shared blend path
  logic signed [15:0]  st_sel;
  logic signed [16:0]  rate_sel;
  logic signed [25:0]  acc_sel, acc0, acc1;
  logic [16:0]         alpha_c;
  logic [63:0]         root_t;
  logic signed [33:0]  ix0, iy0, iy1, ix1;
  logic signed [17:0]  negax;
  logic signed [42:0]  g_w, a_w;
  logic signed [63:0]  s_w;
  logic signed [23:0]  r_w;
  logic signed [15:0]  sat_w;

  assign acc0     = z0_r ? 26'sd0 : c0_r.z;
  assign acc1     = z1_r ? 26'sd0 : c1_r.z;
  assign st_sel   = lane_r ? pitch_r : roll_r;
  assign rate_sel = lane_r ? item_r.ry : item_r.rx;
  assign acc_sel  = lane_r ? acc1 : acc0;
  assign alpha_c  = cfg.blend_alpha[16] ? ALPHA_ONE : cfg.blend_alpha;
  assign root_t   = res_r + bit_r;

  assign negax = -{item_r.ax[16], item_r.ax};
  assign ix0   = {{4{item_r.az[17]}}, item_r.az, 12'b0};
  assign iy0   = {{5{item_r.ay[16]}}, item_r.ay, 12'b0};
  assign iy1   = {{4{negax[17]}}, negax, 12'b0};
  assign ix1   = {3'b0, res_r[30:0]};

  assign g_w = {{3{st_sel[15]}}, st_sel, 24'b0} + {prod_r[41], prod_r};
  assign a_w = {{2{acc_sel[25]}}, acc_sel, 15'b0};
  assign s_w = {{3{hi_r[38]}}, hi_r, 22'b0} + {25'b0, lo_r}
             + {{7{acc_sel[25]}}, acc_sel, 31'b0} + (64'sd1 <<< 39);
  assign r_w = s_w[63:40];
  assign sat_w = (r_w > 24'sd32767)  ? 16'sh7FFF :
                 (r_w < -24'sd32768) ? 16'sh8000 : r_w[15:0];

  assign q_pop      = (state_r == S_IDLE) && !q_empty;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (!q_empty) state_nxt = S_SQ1;
      S_SQ1:  state_nxt = S_SQ2;
      S_SQ2:  state_nxt = S_ROOT;
      S_ROOT: if (cnt_r == ROOT_LAST) state_nxt = S_CORD;
      S_CORD: if (cnt_r[3:0] == CORDIC_LAST) state_nxt = S_BM1;
      S_BM1:  state_nxt = S_BG;
      S_BG:   state_nxt = S_BM2;
      S_BM2:  state_nxt = S_BM3;
      S_BM3:  state_nxt = S_BS;
      S_BS:   state_nxt = lane_r ? S_OUT : S_BM1;
      S_OUT:  if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      roll_r      <= 16'sd0;
      pitch_r     <= 16'sd0;
      out_valid_r <= 1'b0;
      cnt_r       <= 5'd0;
      lane_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // load a finished item, or drop valid once the receiver took it
      if (state_r == S_OUT && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          item_r <= q_head;
          cnt_r  <= 5'd0;
          lane_r <= 1'b0;
        end
        S_SQ1: sq_r <= 36'(item_r.ay * item_r.ay);
        S_SQ2: begin
          sq_r  <= sq_r + 36'(item_r.az * item_r.az);
          res_r <= 64'd0;
          bit_r <= 64'd1 << 62;
        end
        S_ROOT: begin
          if (cnt_r == 5'd0) begin
            // first step reads the fresh radicand
            if ({4'b0, sq_r, 24'b0} >= root_t) begin
              rem_r <= {4'b0, sq_r, 24'b0} - root_t;
              res_r <= (res_r >> 1) + bit_r;
            end else begin
              rem_r <= {4'b0, sq_r, 24'b0};
              res_r <= res_r >> 1;
            end
          end else if (rem_r >= root_t) begin
            rem_r <= rem_r - root_t;
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
          cnt_r <= (cnt_r == ROOT_LAST) ? 5'd0 : cnt_r + 5'd1;
        end
        S_CORD: begin
          if (cnt_r[3:0] == 4'd0) begin
            c0_r <= cstep(prerot(ix0, iy0), 4'd0);
            c1_r <= cstep(prerot(ix1, iy1), 4'd0);
            z0_r <= (ix0 == 34'sd0) && (iy0 == 34'sd0);
            z1_r <= (ix1 == 34'sd0) && (iy1 == 34'sd0);
          end else begin
            c0_r <= cstep(c0_r, cnt_r[3:0]);
            c1_r <= cstep(c1_r, cnt_r[3:0]);
          end
          cnt_r <= (cnt_r[3:0] == CORDIC_LAST) ? 5'd0 : cnt_r + 5'd1;
        end
        S_BM1: prod_r <= 42'(rate_sel * $signed({1'b0, cfg.gyro_step_gain}));
        S_BG:  d_r  <= g_w - a_w;
        S_BM2: lo_r <= alpha_c * d_r[21:0];
        S_BM3: hi_r <= 39'($signed({1'b0, alpha_c}) * $signed(d_r[42:22]));
        S_BS: begin
          if (lane_r) pitch_r <= sat_w;
          else        roll_r  <= sat_w;
          lane_r <= ~lane_r;
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_data_r  <= {5'b0, item_r.rz, item_r.ry, item_r.rx, pitch_r, roll_r};
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// File: rtl/imu_complementary_tilt_filter.sv
`timescale 1ns / 1ps
// Complementary roll/pitch tilt filter for a six-axis IMU.
// in_*  : one raw sample per item; in_tdata from bit 0 up:
//         accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z (16 b signed each).
// out_* : one result per sample; out_tdata from bit 0 up:
//         roll_angle, pitch_angle (16 b, 1/128 deg), rate_x, rate_y, rate_z (17 b).
// cfg_* : register writes, always ready; index 0..7 as the register list,
//         higher indexes ignored. Write only while the block is idle.
// Sequence: the back end takes one item at a time, through squaring (SQ1,
//         SQ2), 32 root steps, 16 CORDIC steps (both angles in parallel),
//         a blend per angle (BM1, BG, BM2, BM3, BS) and the output load.
// A 2-deep queue after the bias stage lets up to two samples wait while one
// is computed, and the output register holds a finished result while the
// next sample is worked on. If the receiver stalls, the back end finishes
// its current item and waits to hand it over; the queue then fills and
// in_tready drops.
// Reset clears the stored angles, the queue and the output, and loads the
// register defaults (alpha about 0.98, step gain 131142, zero biases).
module imu_complementary_tilt_filter import ictf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [95:0]           in_tdata,   // ax, ay, az, gx, gy, gz
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [87:0]           out_tdata,  // roll, pitch, rate_x, rate_y, rate_z, pad
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);
  ictf_cfg_t  cfg_r;
  ictf_item_t push_item, head_item;
  logic       q_push, q_pop, q_full, q_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.blend_alpha    <= ALPHA_RESET;
      cfg_r.gyro_step_gain <= GAIN_RESET;
      cfg_r.abx <= 16'sd0;
      cfg_r.aby <= 16'sd0;
      cfg_r.abz <= 17'sd0;
      cfg_r.gbx <= 16'sd0;
      cfg_r.gby <= 16'sd0;
      cfg_r.gbz <= 16'sd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BLEND_ALPHA: cfg_r.blend_alpha    <= cfg_data[16:0];
        REG_GYRO_GAIN:   cfg_r.gyro_step_gain <= cfg_data;
        REG_ACC_BIAS_X:  cfg_r.abx <= cfg_data[15:0];
        REG_ACC_BIAS_Y:  cfg_r.aby <= cfg_data[15:0];
        REG_ACC_BIAS_Z:  cfg_r.abz <= cfg_data[16:0];
        REG_GYR_BIAS_X:  cfg_r.gbx <= cfg_data[15:0];
        REG_GYR_BIAS_Y:  cfg_r.gby <= cfg_data[15:0];
        REG_GYR_BIAS_Z:  cfg_r.gbz <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // bias removal and acceptance
  ictf_front u_front (
    .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .cfg(cfg_r), .q_full, .q_push, .q_item(push_item)
  );

  ictf_queue u_queue (
    .clk, .rst_n, .push(q_push), .push_item, .pop(q_pop),
    .head_item, .full(q_full), .empty(q_empty)
  );

  // root, CORDIC, blend and output register
  ictf_back u_back (
    .clk, .rst_n, .cfg(cfg_r), .q_empty, .q_head(head_item), .q_pop,
    .out_tvalid, .out_tready, .out_tdata
  );
endmodule
